// ----- hdl/bfc_pkg.sv -----
`timescale 1ns / 1ps

package bfc_pkg;

  localparam int TAPE_DEPTH  = 32768;
  localparam int TAPE_AW     = $clog2(TAPE_DEPTH);
  localparam int STACK_DEPTH = 64;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);
  localparam int PROG_DEPTH  = 65536;
  localparam int PC_W        = 17;
  localparam int FA_W        = 16;

  localparam logic [2:0] OP_INC   = 3'd0;
  localparam logic [2:0] OP_DEC   = 3'd1;
  localparam logic [2:0] OP_RIGHT = 3'd2;
  localparam logic [2:0] OP_LEFT  = 3'd3;
  localparam logic [2:0] OP_OPEN  = 3'd4;
  localparam logic [2:0] OP_CLOSE = 3'd5;
  localparam logic [2:0] OP_WRITE = 3'd6;
  localparam logic [2:0] OP_READ  = 3'd7;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PTR_LOW   = 3'd1;
  localparam logic [2:0] ERR_UNMATCHED = 3'd2;
  localparam logic [2:0] ERR_TAPE_OVF  = 3'd3;
  localparam logic [2:0] ERR_STACK_OVF = 3'd4;

  typedef struct packed {
    logic [FA_W-1:0] fetch_addr;
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            input_taken;
    logic            halted;
    logic [2:0]      error_code;
  } bfc_result_t;

  typedef struct packed {
    logic              clearing;
    logic              stopped;
    logic [2:0]        err;
    logic [STK_CW-1:0] depth;
    logic [STK_CW-1:0] skip_level;
  } bfc_status_t;

endpackage

// ----- hdl/bfc_ram.sv -----
`timescale 1ns / 1ps

module bfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- hdl/bfc_out_buf.sv -----
`timescale 1ns / 1ps

module bfc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  bfc_pkg::bfc_result_t res,
  input  logic                 out_stall,
  output logic                 out_vld,
  output bfc_pkg::bfc_result_t out_res,
  output logic                 skid_full
);
  import bfc_pkg::*;

  logic        main_vld_r, main_vld_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  bfc_result_t main_r, main_nxt;
  bfc_result_t skid_r, skid_nxt;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_nxt     = res;
        main_vld_nxt = load;
      end
    end else if (load) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_vld   = main_vld_r;
  assign out_res   = main_r;
  assign skid_full = skid_vld_r;

endmodule

// ----- hdl/bfc_exec.sv -----
`timescale 1ns / 1ps

module bfc_exec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bfc_pkg::PC_W-1:0]  cfg_len,
  input  logic                      acc,
  input  logic [2:0]                opcode,
  input  logic [7:0]                in_byte,
  output bfc_pkg::bfc_result_t      res,
  output bfc_pkg::bfc_status_t      stat
);
  import bfc_pkg::*;

  logic [PC_W-1:0]    plen_r, plen_nxt;
  logic [TAPE_AW-1:0] dp_r, dp_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt, pc_step;
  logic [STK_CW-1:0]  depth_r, depth_nxt;
  logic [STK_CW-1:0]  skip_r, skip_nxt;
  logic               skipping_r, skipping_nxt;
  logic               stopped_r, stopped_nxt;
  logic [2:0]         err_r, err_nxt, err;
  logic               clr_busy_r, clr_busy_nxt;
  logic [TAPE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic               tfwd_r, tfwd_nxt;
  logic [7:0]         tfwd_d_r;
  logic               sfwd_r, sfwd_nxt;
  logic [FA_W-1:0]    sfwd_d_r;

  logic               t_we, x_we;
  logic [TAPE_AW-1:0] t_waddr;
  logic [7:0]         t_wd, x_wd, t_rdata, cell_val;
  logic               s_we;
  logic [STK_AW-1:0]  s_waddr, s_raddr;
  logic [FA_W-1:0]    s_wd, s_rdata, tos;
  logic               exec_en;

  bfc_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk     (clk),
    .we      (t_we),
    .waddr   (t_waddr),
    .wdata   (t_wd),
    .raddr   (dp_nxt),
    .rdata_r (t_rdata)
  );

  bfc_ram #(.WIDTH(FA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .we      (s_we),
    .waddr   (s_waddr),
    .wdata   (s_wd),
    .raddr   (s_raddr),
    .rdata_r (s_rdata)
  );

  assign cell_val = tfwd_r ? tfwd_d_r : t_rdata;
  assign tos      = sfwd_r ? sfwd_d_r : s_rdata;

  always_comb begin
    plen_nxt = plen_r;
    if (cfg_we) begin
      if (cfg_len > PC_W'(PROG_DEPTH)) begin
        plen_nxt = PC_W'(PROG_DEPTH);
      end else begin
        plen_nxt = cfg_len;
      end
    end
  end

  always_comb begin
    dp_nxt       = dp_r;
    pc_nxt       = pc_r;
    depth_nxt    = depth_r;
    skip_nxt     = skip_r;
    skipping_nxt = skipping_r;
    stopped_nxt  = stopped_r;
    err_nxt      = err_r;
    pc_step      = pc_r + PC_W'(1);
    err          = ERR_NONE;
    x_we         = 1'b0;
    x_wd         = cell_val;
    s_we         = 1'b0;
    res          = '0;
    exec_en      = acc && !stopped_r && (pc_r < plen_r);

    if (acc && !stopped_r && (pc_r >= plen_r)) begin
      stopped_nxt = 1'b1;
    end

    if (exec_en) begin
      if (skipping_r) begin
        case (opcode)
          OP_OPEN: begin
            if ((STK_CW+1)'(depth_r) + (STK_CW+1)'(skip_r) >= (STK_CW+1)'(STACK_DEPTH)) begin
              err = ERR_STACK_OVF;
            end else begin
              skip_nxt = skip_r + STK_CW'(1);
            end
          end
          OP_CLOSE: begin
            if (skip_r == '0) begin
              skipping_nxt = 1'b0;
              depth_nxt    = depth_r - STK_CW'(1);
            end else begin
              skip_nxt = skip_r - STK_CW'(1);
            end
          end
          default: begin
          end
        endcase
      end else begin
        unique case (opcode)
          OP_INC: begin
            x_we = 1'b1;
            x_wd = cell_val + 8'd1;
          end
          OP_DEC: begin
            x_we = 1'b1;
            x_wd = cell_val - 8'd1;
          end
          OP_RIGHT: begin
            if (dp_r == TAPE_AW'(TAPE_DEPTH - 1)) begin
              err = ERR_TAPE_OVF;
            end else begin
              dp_nxt = dp_r + TAPE_AW'(1);
            end
          end
          OP_LEFT: begin
            if (dp_r == '0) begin
              err = ERR_PTR_LOW;
            end else begin
              dp_nxt = dp_r - TAPE_AW'(1);
            end
          end
          OP_OPEN: begin
            if (depth_r >= STK_CW'(STACK_DEPTH)) begin
              err = ERR_STACK_OVF;
            end else begin
              s_we      = 1'b1;
              depth_nxt = depth_r + STK_CW'(1);
              if (cell_val == 8'd0) begin
                skipping_nxt = 1'b1;
                skip_nxt     = '0;
              end
            end
          end
          OP_CLOSE: begin
            if (depth_r == '0) begin
              err = ERR_UNMATCHED;
            end else if (cell_val != 8'd0) begin
              pc_step = PC_W'(tos) + PC_W'(1);
            end else begin
              depth_nxt = depth_r - STK_CW'(1);
            end
          end
          OP_WRITE: begin
            res.out_valid = 1'b1;
            res.out_byte  = cell_val;
          end
          OP_READ: begin
            x_we            = 1'b1;
            x_wd            = in_byte;
            res.input_taken = 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (err != ERR_NONE) begin
        err_nxt     = err;
        stopped_nxt = 1'b1;
      end else begin
        pc_nxt = pc_step;
        if (pc_step >= plen_r) begin
          stopped_nxt = 1'b1;
        end
      end
    end

    res.fetch_addr = pc_nxt[FA_W-1:0];
    res.halted     = stopped_nxt;
    res.error_code = err_nxt;
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      t_we        = 1'b1;
      t_waddr     = clr_cnt_r;
      t_wd        = 8'd0;
      clr_cnt_nxt = clr_cnt_r + TAPE_AW'(1);
      if (clr_cnt_r == TAPE_AW'(TAPE_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end else begin
      t_we    = x_we;
      t_waddr = dp_r;
      t_wd    = x_wd;
    end
  end

  assign tfwd_nxt = t_we && (t_waddr == dp_nxt);

  assign s_waddr  = depth_r[STK_AW-1:0];
  assign s_wd     = pc_r[FA_W-1:0];
  assign s_raddr  = STK_AW'(depth_nxt - STK_CW'(1));
  assign sfwd_nxt = s_we && (s_waddr == s_raddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= '0;
      dp_r       <= '0;
      pc_r       <= '0;
      depth_r    <= '0;
      skip_r     <= '0;
      skipping_r <= 1'b0;
      stopped_r  <= 1'b0;
      err_r      <= ERR_NONE;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      tfwd_r     <= 1'b0;
      sfwd_r     <= 1'b0;
    end else begin
      plen_r     <= plen_nxt;
      dp_r       <= dp_nxt;
      pc_r       <= pc_nxt;
      depth_r    <= depth_nxt;
      skip_r     <= skip_nxt;
      skipping_r <= skipping_nxt;
      stopped_r  <= stopped_nxt;
      err_r      <= err_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      tfwd_r     <= tfwd_nxt;
      sfwd_r     <= sfwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tfwd_d_r <= t_wd;
    sfwd_d_r <= s_wd;
  end

  assign stat.clearing   = clr_busy_r;
  assign stat.stopped    = stopped_r;
  assign stat.err        = err_r;
  assign stat.depth      = depth_r;
  assign stat.skip_level = skip_r;

endmodule

// ----- hdl/brainfuck_execution_core.sv -----
// A result is registered in the output buffer (skid entry while out_stall holds the
// main one) before the out_ channel shows it. Throughput: one instruction per cycle
// while in_stall is low; tape and loop-stack memories are read at the next data
// pointer and stack top, with write forwarding. Reset: rst_n is synchronous, active
// low; after release the tape is cleared while in_stall is high; cfg writes still land.
`timescale 1ns / 1ps

module brainfuck_execution_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bfc_pkg::PC_W-1:0] cfg_program_length,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_opcode,
  input  logic [7:0]               in_input_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [bfc_pkg::FA_W-1:0] out_fetch_addr,
  output logic                     out_out_valid,
  output logic [7:0]               out_out_byte,
  output logic                     out_input_taken,
  output logic                     out_halted,
  output logic [2:0]               out_error_code
);
  import bfc_pkg::*;

  bfc_result_t res, out_res;
  bfc_status_t stat;
  logic        acc;
  logic        skid_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = stat.clearing || skid_full;
  assign acc       = in_valid && !in_stall;

  bfc_exec u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_len (cfg_program_length),
    .acc     (acc),
    .opcode  (in_opcode),
    .in_byte (in_input_byte),
    .res     (res),
    .stat    (stat)
  );

  bfc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc),
    .res       (res),
    .out_stall (out_stall),
    .out_vld   (out_valid),
    .out_res   (out_res),
    .skid_full (skid_full)
  );

  assign out_fetch_addr  = out_res.fetch_addr;
  assign out_out_valid   = out_res.out_valid;
  assign out_out_byte    = out_res.out_byte;
  assign out_input_taken = out_res.input_taken;
  assign out_halted      = out_res.halted;
  assign out_error_code  = out_res.error_code;

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.stopped |=> stat.stopped)
    else $error("halt state dropped");

  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.err != ERR_NONE) |-> stat.stopped)
    else $error("error held without halt");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((STK_CW+1)'(stat.depth) + (STK_CW+1)'(stat.skip_level)) <= (STK_CW+1)'(STACK_DEPTH))
    else $error("loop nesting beyond stack depth");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_valid)
    else $error("skid entry without output entry");
`endif

endmodule
